// ===== src/lcd_segment_image_writer_core_assert.svh =====
// ----------------------------------------------------------------------------
// LCD segment image writer assertion macros
// Wrappers for concurrent checks; they compile away when SYNTH is defined.
// ----------------------------------------------------------------------------
`ifndef LCD_SEGMENT_IMAGE_WRITER_CORE_ASSERT_SVH
`define LCD_SEGMENT_IMAGE_WRITER_CORE_ASSERT_SVH

`ifndef SYNTH
// Same-cycle implication check
`define LSIW_ASSERT_IMP(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lsiw: implication check failed");
// Next-cycle implication check
`define LSIW_ASSERT_NXT(name, clk, rst, ante, cons) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lsiw: next-cycle check failed");
`else
`define LSIW_ASSERT_IMP(name, clk, rst, ante, cons)
`define LSIW_ASSERT_NXT(name, clk, rst, ante, cons)
`endif

`endif

// ===== src/lsiw_pkg.sv =====
// ----------------------------------------------------------------------------
// LCD segment image writer package
// Command codes, pipeline request types, segment ROM and digit patterns.
// ----------------------------------------------------------------------------
package lsiw_pkg;

  localparam int unsigned ImageBytes  = 32;
  localparam int unsigned SegCount    = 176;
  localparam int unsigned BinWidth    = 32;
  localparam int unsigned BcdDigits   = 10;
  localparam int unsigned BcdWidth    = 4 * BcdDigits;
  localparam int unsigned BcdStages   = 4;
  localparam int unsigned StageIters  = BinWidth / BcdStages;
  localparam int unsigned MainDigits  = 9;
  localparam int unsigned SmallDigits = 3;

  typedef enum logic [1:0] {
    CMD_SET_SEG = 2'd0,
    CMD_MAIN    = 2'd1,
    CMD_SMALL   = 2'd2,
    CMD_CLEAR   = 2'd3
  } lsiw_cmd_t;

  // Decoded command that rides alongside the number conversion
  typedef struct packed {
    lsiw_cmd_t   cmd;
    logic        seg_on;
    logic        range_err;
    logic [4:0]  img_byte;
    logic [7:0]  mask;
  } lsiw_side_t;

  // One request in flight: command plus binary-to-BCD working state
  typedef struct packed {
    lsiw_side_t             side;
    logic [BinWidth-1:0]    bin;
    logic [BcdWidth-1:0]    bcd;
  } lsiw_item_t;

  // Segment id to image byte index
  localparam logic [4:0] SEG_BYTE [SegCount] = '{
     2,28,21,21,21,21, 4, 6, 8,10,12,14,16,18,20, 9,15,23, 0,19,
     8, 0, 1, 0, 0, 0, 1, 1, 1, 2, 1, 2, 2, 2, 2, 2, 2, 3, 4,12,
    11,10,21,21,21,21,22,22,22,22,22,22,22, 9,15,18, 8,10,16,19,
     0, 0,31,31,31,30,30,27,28,20,25,13,14,20, 5, 6, 7,
     1, 1, 1,31,31,31,31,30,30,30,30,29,29,29,29,
     4, 4, 4, 3, 3, 3, 3,  6, 6, 6, 5, 5, 5, 5,  8, 8, 8, 7, 7, 7, 7,
    10,10,10, 9, 9, 9, 9, 12,12,12,11,11,11,11, 14,14,14,13,13,13,13,
    16,16,16,15,15,15,15, 18,18,18,17,17,17,17, 20,20,20,19,19,19,19,
    27,27,27,27,28,28,28, 25,25,25,25,26,26,26, 23,23,23,23,24,24,24
  };

  // Segment id to bit mask within its byte
  localparam logic [7:0] SEG_MASK [SegCount] = '{
    8'h01,8'h10,8'h01,8'h02,8'h04,8'h08,8'h08,8'h08,8'h08,8'h08,
    8'h08,8'h08,8'h08,8'h08,8'h08,8'h10,8'h10,8'h01,8'h80,8'h10,
    8'h10,8'h02,8'h01,8'h10,8'h20,8'h40,8'h40,8'h10,8'h20,8'h20,
    8'h80,8'h02,8'h04,8'h08,8'h10,8'h40,8'h80,8'h10,8'h10,8'h10,
    8'h10,8'h10,8'h10,8'h20,8'h40,8'h80,8'h01,8'h02,8'h04,8'h10,
    8'h20,8'h40,8'h80,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,8'h20,
    8'h04,8'h08,8'h04,8'h01,8'h02,8'h01,8'h02,8'h01,8'h01,8'h20,
    8'h01,8'h10,8'h10,8'h10,8'h10,8'h10,8'h10,
    8'h08,8'h04,8'h02,8'h80,8'h40,8'h20,8'h10,8'h10,8'h20,8'h40,
    8'h80,8'h80,8'h40,8'h20,8'h10,
    8'h01,8'h02,8'h04,8'h08,8'h04,8'h01,8'h02, 8'h01,8'h02,8'h04,8'h08,8'h04,8'h01,8'h02,
    8'h01,8'h02,8'h04,8'h08,8'h04,8'h01,8'h02, 8'h01,8'h02,8'h04,8'h08,8'h04,8'h01,8'h02,
    8'h01,8'h02,8'h04,8'h08,8'h04,8'h01,8'h02, 8'h01,8'h02,8'h04,8'h08,8'h04,8'h01,8'h02,
    8'h01,8'h02,8'h04,8'h08,8'h04,8'h01,8'h02, 8'h01,8'h02,8'h04,8'h08,8'h04,8'h01,8'h02,
    8'h01,8'h02,8'h04,8'h08,8'h04,8'h01,8'h02,
    8'h80,8'h40,8'h20,8'h10,8'h20,8'h80,8'h40, 8'h80,8'h40,8'h20,8'h10,8'h20,8'h80,8'h40,
    8'h80,8'h40,8'h20,8'h10,8'h20,8'h80,8'h40
  };

  // Main display, A/B/C bits of the high byte
  function automatic logic [7:0] main_hi(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0: p = 8'h07;
      4'd1: p = 8'h06;
      4'd2: p = 8'h03;
      4'd3: p = 8'h07;
      4'd4: p = 8'h06;
      4'd5: p = 8'h05;
      4'd6: p = 8'h05;
      4'd7: p = 8'h07;
      4'd8: p = 8'h07;
      4'd9: p = 8'h07;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Main display, F/G/E/D bits of the low byte
  function automatic logic [7:0] main_lo(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0: p = 8'h0D;
      4'd1: p = 8'h00;
      4'd2: p = 8'h0E;
      4'd3: p = 8'h0A;
      4'd4: p = 8'h03;
      4'd5: p = 8'h0B;
      4'd6: p = 8'h0F;
      4'd7: p = 8'h00;
      4'd8: p = 8'h0F;
      4'd9: p = 8'h0B;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Small display, D/C/B/A bits
  function automatic logic [7:0] small_hi(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0: p = 8'hF0;
      4'd1: p = 8'h60;
      4'd2: p = 8'hD0;
      4'd3: p = 8'hF0;
      4'd4: p = 8'h60;
      4'd5: p = 8'hB0;
      4'd6: p = 8'hB0;
      4'd7: p = 8'hE0;
      4'd8: p = 8'hF0;
      4'd9: p = 8'hF0;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

  // Small display, E/G/F bits
  function automatic logic [7:0] small_lo(input logic [3:0] d);
    logic [7:0] p;
    unique case (d)
      4'd0: p = 8'hA0;
      4'd1: p = 8'h00;
      4'd2: p = 8'h60;
      4'd3: p = 8'h40;
      4'd4: p = 8'hC0;
      4'd5: p = 8'hC0;
      4'd6: p = 8'hE0;
      4'd7: p = 8'h00;
      4'd8: p = 8'hE0;
      4'd9: p = 8'hC0;
      default: p = 8'h00;
    endcase
    return p;
  endfunction

endpackage

// ===== src/lsiw_bcd_stage.sv =====
// ----------------------------------------------------------------------------
// LCD segment image writer BCD stage
// One registered pipeline stage of shift-and-add-3 binary to BCD conversion.
// ----------------------------------------------------------------------------
module lsiw_bcd_stage (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  lsiw_pkg::lsiw_item_t in_item,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output lsiw_pkg::lsiw_item_t out_item
);
  import lsiw_pkg::*;

  logic                valid;
  lsiw_item_t          item;
  logic [BinWidth-1:0] work_bin;
  logic [BcdWidth-1:0] work_bcd;

  // Accept when empty or when the held request moves on
  assign in_ready  = !valid || out_ready;
  assign out_valid = valid;
  assign out_item  = item;

  // Run this stage's share of shift-and-add-3 steps
  always_comb begin
    work_bin = in_item.bin;
    work_bcd = in_item.bcd;
    for (int i = 0; i < StageIters; i++) begin
      for (int n = 0; n < BcdDigits; n++) begin
        if (work_bcd[4*n +: 4] >= 4'd5) begin
          work_bcd[4*n +: 4] = work_bcd[4*n +: 4] + 4'd3;
        end
      end
      {work_bcd, work_bin} = {work_bcd[BcdWidth-2:0], work_bin, 1'b0};
    end
  end

  // Hold valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (in_ready) begin
      valid <= in_valid;
    end
  end

  // Capture the advanced request
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item.side <= in_item.side;
      item.bin  <= work_bin;
      item.bcd  <= work_bcd;
    end
  end

endmodule

// ===== src/lsiw_image_update.sv =====
// ----------------------------------------------------------------------------
// LCD segment image writer image update
// Holds the segment image and applies one decoded request per cycle unless the result is stalled.
// ----------------------------------------------------------------------------
`include "lcd_segment_image_writer_core_assert.svh"

module lsiw_image_update (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  lsiw_pkg::lsiw_item_t             in_item,
  output logic                             in_ready,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             status,
  output logic [8*lsiw_pkg::ImageBytes-1:0] image
);
  import lsiw_pkg::*;

  logic [7:0]           img      [ImageBytes];
  logic [7:0]           img_next [ImageBytes];
  logic                 status_next;
  logic                 saturate;
  logic [BcdDigits-1:0] main_nz;
  logic [SmallDigits-1:0] small_nz;
  logic [3:0]           dig;

  // Take a request only when the result register is free
  assign in_ready = !out_valid || out_ready;

  // Any number of 1e9 or more shows as all nines
  assign saturate = in_item.bcd[BcdWidth-1 -: 4] != 4'd0;

  // Flag digits with a nonzero digit at or above them
  always_comb begin
    main_nz[BcdDigits-1] = in_item.bcd[4*(BcdDigits-1) +: 4] != 4'd0;
    for (int k = BcdDigits - 2; k >= 0; k--) begin
      main_nz[k] = main_nz[k+1] || (in_item.bcd[4*k +: 4] != 4'd0);
    end
    small_nz[SmallDigits-1] = in_item.bcd[4*(SmallDigits-1) +: 4] != 4'd0;
    for (int k = SmallDigits - 2; k >= 0; k--) begin
      small_nz[k] = small_nz[k+1] || (in_item.bcd[4*k +: 4] != 4'd0);
    end
  end

  // Build the next image
  always_comb begin
    img_next    = img;
    status_next = 1'b0;
    dig         = 4'd0;
    unique case (in_item.side.cmd)
      CMD_SET_SEG: begin
        if (in_item.side.range_err) begin
          status_next = 1'b1;
        end else begin
          for (int b = 0; b < ImageBytes; b++) begin
            if (5'(b) == in_item.side.img_byte) begin
              img_next[b] = in_item.side.seg_on ? (img[b] | in_item.side.mask)
                                                : (img[b] & ~in_item.side.mask);
            end
          end
        end
      end
      CMD_MAIN: begin
        for (int k = 0; k < MainDigits; k++) begin
          dig = saturate ? 4'd9 : in_item.bcd[4*k +: 4];
          img_next[20-2*k] = img[20-2*k] & 8'hF8;
          img_next[19-2*k] = img[19-2*k] & 8'hF0;
          if (k == 0 || saturate || main_nz[k]) begin
            img_next[20-2*k] = img_next[20-2*k] | main_hi(dig);
            img_next[19-2*k] = img_next[19-2*k] | main_lo(dig);
          end
        end
      end
      CMD_SMALL: begin
        for (int k = 0; k < SmallDigits; k++) begin
          dig = in_item.bcd[4*k +: 4];
          img_next[23+2*k] = img[23+2*k] & 8'h0F;
          img_next[24+2*k] = img[24+2*k] & 8'h1F;
          if (k == 0 || small_nz[k]) begin
            img_next[23+2*k] = img_next[23+2*k] | small_hi(dig);
            img_next[24+2*k] = img_next[24+2*k] | small_lo(dig);
          end
        end
      end
      CMD_CLEAR: begin
        for (int b = 0; b < ImageBytes; b++) begin
          img_next[b] = 8'h00;
        end
      end
      default: begin
        status_next = 1'b0;
      end
    endcase
  end

  // Advance image and result flag
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int b = 0; b < ImageBytes; b++) begin
        img[b] <= 8'h00;
      end
    end else if (in_ready) begin
      out_valid <= in_valid;
      if (in_valid) begin
        img <= img_next;
      end
    end
  end

  // Capture status with the result
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      status <= status_next;
    end
  end

  // Flatten image, byte 0 lowest
  always_comb begin
    for (int b = 0; b < ImageBytes; b++) begin
      image[8*b +: 8] = img[b];
    end
  end

  `LSIW_ASSERT_NXT(a_hold_image, clk, rst, out_valid && !out_ready, $stable(image))
  `LSIW_ASSERT_NXT(a_clear_zero, clk, rst, in_valid && in_ready && in_item.side.cmd == CMD_CLEAR, image == '0)
  `LSIW_ASSERT_NXT(a_range_keep, clk, rst, in_valid && in_ready && in_item.side.cmd == CMD_SET_SEG && in_item.side.range_err, $stable(image) && status)

endmodule

// ===== src/lcd_segment_image_writer_core.sv =====
// ----------------------------------------------------------------------------
// LCD segment image writer core
// Keeps a 32-byte LCD segment image and updates it by set/clear-segment,
// main number, small number and clear commands.
// ----------------------------------------------------------------------------
// Pipeline: a request passes four registered BCD stages, then the image/result
//   register, which raises m_tvalid.
// Throughput: one request per cycle; the BCD pipeline stages and the image
//   register each take a new request every cycle when not stalled.
// Reset: rst clears the image to all zeros and empties the pipeline.
module lcd_segment_image_writer_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // command[1:0], segment number[9:2], seg_on[10], number[42:11], zero pad
  input  logic [47:0]  s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // status[0], image_bytes_0_7[64:1], image_bytes_8_15[128:65],
  // image_bytes_16_23[192:129], image_bytes_24_31[256:193], zero pad
  output logic [263:0] m_tdata
);
  import lsiw_pkg::*;

  logic [1:0]          command;
  logic [7:0]          seg_num;
  logic                seg_on;
  logic [BinWidth-1:0] number;
  logic                in_range;
  lsiw_item_t          first_item;

  logic       stage_valid [BcdStages+1];
  logic       stage_ready [BcdStages+1];
  lsiw_item_t stage_item  [BcdStages+1];

  logic                      status;
  logic [8*ImageBytes-1:0]   image;

  // Unpack request fields
  assign command = s_tdata[1:0];
  assign seg_num = s_tdata[9:2];
  assign seg_on  = s_tdata[10];
  assign number  = s_tdata[42:11];

  // Decode and look up the segment ROM
  assign in_range = 32'(seg_num) < SegCount;
  always_comb begin
    first_item.side.cmd       = lsiw_cmd_t'(command);
    first_item.side.seg_on    = seg_on;
    first_item.side.range_err = !in_range;
    first_item.side.img_byte  = in_range ? SEG_BYTE[seg_num] : 5'd0;
    first_item.side.mask      = in_range ? SEG_MASK[seg_num] : 8'h00;
    first_item.bin            = number;
    first_item.bcd            = '0;
  end

  assign stage_valid[0] = s_tvalid;
  assign stage_item[0]  = first_item;
  assign s_tready       = stage_ready[0];

  // Binary to BCD pipeline
  for (genvar g = 0; g < BcdStages; g++) begin : g_bcd
    lsiw_bcd_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (stage_valid[g]),
      .in_item   (stage_item[g]),
      .in_ready  (stage_ready[g]),
      .out_valid (stage_valid[g+1]),
      .out_ready (stage_ready[g+1]),
      .out_item  (stage_item[g+1])
    );
  end

  // Image register and result
  lsiw_image_update u_update (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (stage_valid[BcdStages]),
    .in_item   (stage_item[BcdStages]),
    .in_ready  (stage_ready[BcdStages]),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .status    (status),
    .image     (image)
  );

  assign m_tdata = {7'd0, image, status};

endmodule
